// ===== rtl/mrrb_pkg.sv =====
package mrrb_pkg;

	localparam int DEPTH_DEF       = 2048;
	localparam int MAX_READERS_DEF = 8;

	localparam int IDX_W  = 3;
	localparam int CFG_W  = 4;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 11;

	localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'd2047;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Status of the occupancy scan, seen by the controller.
	typedef struct packed {
		logic busy;
		logic rd_en;
		logic done;
	} scan_st_t;

	// Bytes between a read pointer and the write pointer on a ring of depth entries.
	function automatic logic [31:0] occupancy(input logic [31:0] wp, input logic [31:0] rp,
		input logic [31:0] depth);
		if (wp >= rp) begin
			return wp - rp;
		end
		return (depth - rp) + wp;
	endfunction

	// Counts wider than the result fields saturate.
	function automatic logic [CNT_W-1:0] clip_count(input logic [31:0] v);
		if (v > 32'(COUNT_LIMIT)) begin
			return COUNT_LIMIT;
		end
		return v[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/mrrb_if.sv =====
interface mrrb_req_if;
	import mrrb_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [IDX_W-1:0]  reader_index;
	logic [BYTE_W-1:0] write_byte;

	modport source (output valid, output op, output reader_index, output write_byte,
		input ready);
	modport sink (input valid, input op, input reader_index, input write_byte,
		output ready);
endinterface

interface mrrb_rsp_if;
	import mrrb_pkg::*;

	logic              valid;
	logic              ready;
	logic              accepted;
	logic [BYTE_W-1:0] read_byte;
	logic [CNT_W-1:0]  reader_waiting;
	logic [CNT_W-1:0]  free_space;

	modport source (output valid, output accepted, output read_byte, output reader_waiting,
		output free_space, input ready);
	modport sink (input valid, input accepted, input read_byte, input reader_waiting,
		input free_space, output ready);
endinterface

// ===== rtl/multi_reader_ring_buffer.sv =====
// Byte ring buffer with one writer and up to MAX_READERS readers, each reader
// with its own read pointer so that every reader sees every byte. A request
// word either writes one byte (op write) or reads one byte for reader_index
// (op read), and every request gives exactly one response word with the
// accepted flag, the byte read, the addressed reader's waiting count and the
// writer's free space after the step. The writer is held back by the slowest
// active reader: free space is DEPTH minus the largest occupancy over readers
// 0 to reader_count-1, minus one. Bytes live in a DEPTH-entry memory and the
// read pointers in a small pointer memory, both with registered reads. A
// request passes through acceptance with the pointer read, lookup with the
// byte write or read and the pointer write-back, and the response load. The
// largest occupancy is kept in a register and moves with each write. A read
// by a reader that held that maximum adds a scan of the pointer memory, one
// reader per cycle, and the first request after a write to reader_count waits
// for the same scan. A response that waits to be taken does not block the
// next request from being accepted. There is no clearing pass after reset:
// pointer entries carry valid bits and the byte memory is never read where
// it was not written.
module multi_reader_ring_buffer #(
	parameter int DEPTH       = mrrb_pkg::DEPTH_DEF,
	parameter int MAX_READERS = mrrb_pkg::MAX_READERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mrrb_req_if.sink                   req,
	mrrb_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [mrrb_pkg::CFG_W-1:0] cfg_wdata
);
	import mrrb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int NW = $clog2(MAX_READERS + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_FIN
	} state_t;

	state_t            state_q;
	logic              stale_q;
	logic              scan_item_q;
	logic [NW-1:0]     nact_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     max_q;

	// Request held through the lookup.
	logic              op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] wbyte_q;

	// Response under construction.
	logic              acc_q;
	logic [CNT_W-1:0]  wait_q;
	logic              look_s1;
	logic              rdacc_s1;
	logic [BYTE_W-1:0] rbyte_q;

	// Response register.
	logic              rsp_valid_q;
	logic              rsp_acc_q;
	logic [BYTE_W-1:0] rsp_byte_q;
	logic [CNT_W-1:0]  rsp_wait_q;
	logic [CNT_W-1:0]  rsp_free_q;

	logic              in_act;
	logic              rsp_load;
	logic [RW-1:0]     req_addr;
	logic [RW-1:0]     idx_addr;
	logic [NW-1:0]     nact_d;
	logic              active;
	logic [AW-1:0]     ptr_rdata;
	logic [AW-1:0]     ptr_next;
	logic [AW-1:0]     occ_r;
	logic              wr_ok;
	logic              rd_ok;
	logic              look_acc;
	logic [AW-1:0]     wait_d;
	logic              need_scan;
	logic              store_we;
	logic              store_re;
	logic [BYTE_W-1:0] store_rdata;
	logic              ptr_we;
	logic              ptr_re;
	logic [RW-1:0]     ptr_raddr;
	logic              scan_start;
	scan_st_t          scan_st;
	logic [RW-1:0]     scan_addr;
	logic [AW-1:0]     scan_max;
	logic [BYTE_W-1:0] rbyte_now;
	logic [AW-1:0]     wp_next;

	// New requests wait while the stored maximum is out of date after a
	// reader_count write; the scan that refreshes it starts from idle.
	assign req.ready = (state_q == S_IDLE) && !stale_q;
	assign in_act    = req.valid && req.ready;

	// Readers beyond the pointer memory are never active, so their address
	// only needs to stay in range.
	assign req_addr = (32'(req.reader_index) < MAX_READERS) ? RW'(32'(req.reader_index)) : '0;
	assign idx_addr = (32'(idx_q) < MAX_READERS) ? RW'(32'(idx_q)) : '0;

	// Reader count zero counts as one, and counts above the pointer memory
	// are held at its size.
	always_comb begin
		if (cfg_wdata == '0) begin
			nact_d = NW'(1);
		end else if (32'(cfg_wdata) > MAX_READERS) begin
			nact_d = NW'(MAX_READERS);
		end else begin
			nact_d = NW'(cfg_wdata);
		end
	end

	// Lookup: the addressed reader's pointer has arrived from the pointer memory.
	assign active   = 32'(idx_q) < 32'(nact_q);
	assign occ_r    = AW'(occupancy(32'(wp_q), 32'(ptr_rdata), 32'(DEPTH)));
	assign ptr_next = (ptr_rdata == LAST) ? '0 : ptr_rdata + AW'(1);
	assign wp_next  = (wp_q == LAST) ? '0 : wp_q + AW'(1);
	assign wr_ok    = max_q != LAST;
	assign rd_ok    = active && (occ_r != '0);
	assign look_acc = (op_q == OP_READ) ? rd_ok : wr_ok;

	// A write moves every reader's occupancy up by one, so the maximum moves
	// with it. A read that drains the reader at the maximum may lower it,
	// and only a scan can tell.
	assign need_scan = (op_q == OP_READ) && rd_ok && (occ_r == max_q);

	always_comb begin
		if (!active) begin
			wait_d = '0;
		end else if (op_q == OP_READ) begin
			wait_d = occ_r - AW'(rd_ok);
		end else begin
			wait_d = occ_r + AW'(wr_ok);
		end
	end

	assign store_we = (state_q == S_LOOK) && (op_q == OP_WRITE) && wr_ok;
	assign store_re = (state_q == S_LOOK) && (op_q == OP_READ) && rd_ok;
	assign ptr_we   = store_re;

	// The pointer memory has one read port: the request lookup uses it in
	// idle and the scan while it runs, never both at once.
	assign ptr_re    = in_act || scan_st.rd_en;
	assign ptr_raddr = scan_st.busy ? scan_addr : req_addr;

	assign scan_start = ((state_q == S_IDLE) && stale_q) || ((state_q == S_LOOK) && need_scan);

	// The byte read in the lookup arrives in the cycle after it.
	assign rbyte_now = look_s1 ? (rdacc_s1 ? store_rdata : '0) : rbyte_q;

	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stale_q     <= 1'b0;
			scan_item_q <= 1'b0;
			nact_q      <= NW'(1);
			wp_q        <= '0;
			max_q       <= '0;
			look_s1     <= 1'b0;
			rdacc_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			look_s1  <= state_q == S_LOOK;
			rdacc_s1 <= store_re;
			if (look_s1) begin
				rbyte_q <= rdacc_s1 ? store_rdata : '0;
			end

			if (cfg_we) begin
				nact_q  <= nact_d;
				stale_q <= 1'b1;
			end else if ((state_q == S_IDLE) && stale_q) begin
				stale_q <= 1'b0;
			end

			// A new word may replace the one being taken in the same cycle.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (stale_q) begin
						scan_item_q <= 1'b0;
						state_q     <= S_SCAN;
					end else if (in_act) begin
						op_q    <= req.op;
						idx_q   <= req.reader_index;
						wbyte_q <= req.write_byte;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					acc_q  <= look_acc;
					wait_q <= clip_count(32'(wait_d));
					if (store_we) begin
						wp_q  <= wp_next;
						max_q <= max_q + AW'(1);
					end
					if (need_scan) begin
						scan_item_q <= 1'b1;
						state_q     <= S_SCAN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (scan_st.done) begin
						max_q   <= scan_max;
						state_q <= scan_item_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						rsp_acc_q   <= acc_q;
						rsp_byte_q  <= rbyte_now;
						rsp_wait_q  <= wait_q;
						rsp_free_q  <= clip_count(32'(LAST - max_q));
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mrrb_byte_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q),
		.wdata (wbyte_q),
		.re    (store_re),
		.raddr (ptr_rdata),
		.rdata (store_rdata)
	);

	mrrb_ptr_mem #(
		.MAX_READERS (MAX_READERS),
		.AW          (AW),
		.RW          (RW)
	) u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ptr_we),
		.waddr  (idx_addr),
		.wdata  (ptr_next),
		.re     (ptr_re),
		.raddr  (ptr_raddr),
		.rdata  (ptr_rdata)
	);

	mrrb_max_scan #(
		.DEPTH       (DEPTH),
		.MAX_READERS (MAX_READERS),
		.AW          (AW),
		.RW          (RW),
		.NW          (NW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.nact    (nact_q),
		.wp      (wp_q),
		.rd_data (ptr_rdata),
		.rd_addr (scan_addr),
		.st      (scan_st),
		.max_o   (scan_max)
	);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.accepted       = rsp_acc_q;
	assign rsp.read_byte      = rsp_byte_q;
	assign rsp.reader_waiting = rsp_wait_q;
	assign rsp.free_space     = rsp_free_q;

endmodule

// ===== rtl/mrrb_byte_store.sv =====
module mrrb_byte_store #(
	parameter int DEPTH = mrrb_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [mrrb_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [mrrb_pkg::BYTE_W-1:0] rdata
);
	import mrrb_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mrrb_ptr_mem.sv =====
module mrrb_ptr_mem #(
	parameter int MAX_READERS = mrrb_pkg::MAX_READERS_DEF,
	parameter int AW          = 11,
	parameter int RW          = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [RW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0]          mem [MAX_READERS];
	logic [MAX_READERS-1:0] valid_q;
	logic [AW-1:0]          rdata_q;
	logic                   rvalid_q;

	// An entry never written since reset reads as a zero pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/mrrb_max_scan.sv =====
module mrrb_max_scan #(
	parameter int DEPTH       = mrrb_pkg::DEPTH_DEF,
	parameter int MAX_READERS = mrrb_pkg::MAX_READERS_DEF,
	parameter int AW          = $clog2(DEPTH),
	parameter int RW          = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1,
	parameter int NW          = $clog2(MAX_READERS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NW-1:0]        nact,
	input  logic [AW-1:0]        wp,
	input  logic [AW-1:0]        rd_data,
	output logic [RW-1:0]        rd_addr,
	output mrrb_pkg::scan_st_t   st,
	output logic [AW-1:0]        max_o
);
	import mrrb_pkg::*;

	logic [NW-1:0] idx_q;
	logic          busy_q;
	logic          iss_s1;
	logic          vld_s2;
	logic [AW-1:0] occ_s2;
	logic [AW-1:0] acc_q;
	logic          rd_en;
	logic          done;

	assign rd_en = busy_q && (idx_q < nact);
	assign done  = busy_q && !rd_en && !iss_s1 && !vld_s2;

	// Read pointer, then occupancy, then running maximum: one reader per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
			iss_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			iss_s1 <= rd_en;
			vld_s2 <= iss_s1;
			if (start) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (rd_en) begin
				idx_q <= idx_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (iss_s1) begin
			occ_s2 <= AW'(occupancy(32'(wp), 32'(rd_data), 32'(DEPTH)));
		end
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2 && (occ_s2 > acc_q)) begin
			acc_q <= occ_s2;
		end
	end

	assign rd_addr  = idx_q[RW-1:0];
	assign st.busy  = busy_q;
	assign st.rd_en = rd_en;
	assign st.done  = done;
	assign max_o    = acc_q;

endmodule

// ===== rtl/mrrb_checker.sv =====
module mrrb_checker #(
	parameter int DEPTH = mrrb_pkg::DEPTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_accepted,
	input logic [mrrb_pkg::BYTE_W-1:0] rsp_read_byte,
	input logic [mrrb_pkg::CNT_W-1:0]  rsp_reader_waiting,
	input logic [mrrb_pkg::CNT_W-1:0]  rsp_free_space
);
	import mrrb_pkg::*;

	// A stalled response word keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
			&& $stable(rsp_read_byte) && $stable(rsp_reader_waiting)
			&& $stable(rsp_free_space))
		else $error("stalled response word changed");

	// Refused requests, writes or reads, report a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_accepted |-> rsp_read_byte == '0)
		else $error("refused request reported a nonzero byte");

	// No reader can hold more than the writer has kept from the free space.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH > 32'(COUNT_LIMIT) + 1)
			|| (32'(rsp_reader_waiting) + 32'(rsp_free_space) <= 32'(DEPTH - 1)))
		else $error("waiting count and free space exceed the ring");

	// Each request runs through a lookup before the next is taken.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

endmodule

bind multi_reader_ring_buffer mrrb_checker #(.DEPTH(DEPTH)) u_mrrb_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_accepted       (rsp.accepted),
	.rsp_read_byte      (rsp.read_byte),
	.rsp_reader_waiting (rsp.reader_waiting),
	.rsp_free_space     (rsp.free_space)
);

// ===== sim/tb_multi_reader_ring_buffer.sv =====
`timescale 1ns / 1ps

module tb_multi_reader_ring_buffer;
	import mrrb_pkg::*;

	// The block is built at its default size, so the predictor uses the same numbers.
	localparam int RING_DEPTH = DEPTH_DEF;
	localparam int READERS    = MAX_READERS_DEF;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int RD_W       = (READERS > 1) ? $clog2(READERS) : 1;

	// One response word as the block should deliver it.
	typedef struct {
		logic              accepted;
		logic [BYTE_W-1:0] read_byte;
		logic [CNT_W-1:0]  waiting;
		logic [CNT_W-1:0]  room;
	} reply_t;

	// Shadow copy of the ring. Every accepted request word is applied here in
	// acceptance order, and the response it must cause is queued until the block
	// delivers it.
	class ring_tracker;
		logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
		int unsigned       wr_ptr = 0;
		int unsigned       rd_ptr [READERS] = '{default: 0};
		logic [CFG_W-1:0]  reader_cfg = CFG_W'(1);
		reply_t            due_replies [$];
		int                mismatches = 0;

		// A programmed count of zero acts as one reader, and anything above the
		// number of pointers acts as all of them.
		function int unsigned live_readers();
			if (reader_cfg == 0) begin
				return 1;
			end
			if (reader_cfg > READERS) begin
				return READERS;
			end
			return 32'(reader_cfg);
		endfunction

		function int unsigned backlog(input int unsigned r);
			if (wr_ptr >= rd_ptr[r[RD_W-1:0]]) begin
				return wr_ptr - rd_ptr[r[RD_W-1:0]];
			end
			return RING_DEPTH - rd_ptr[r[RD_W-1:0]] + wr_ptr;
		endfunction

		// The writer is held back by the slowest active reader.
		function int unsigned room_left();
			int unsigned worst = 0;
			for (int unsigned i = 0; i < live_readers(); i++) begin
				if (backlog(i) > worst) begin
					worst = backlog(i);
				end
			end
			return RING_DEPTH - worst - 1;
		endfunction

		function logic [CNT_W-1:0] count_field(input int unsigned v);
			if (v > COUNT_LIMIT) begin
				return COUNT_LIMIT;
			end
			return v[CNT_W-1:0];
		endfunction

		function void log_request(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] b);
			reply_t r;
			bit     active;
			r.accepted  = 1'b0;
			r.read_byte = '0;
			r.waiting   = '0;
			active      = idx < live_readers();
			if (op == OP_WRITE) begin
				if (room_left() > 0) begin
					ring_bytes[wr_ptr[RING_AW-1:0]] = b;
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					r.accepted = 1'b1;
				end
			end else if (active && backlog(32'(idx)) > 0) begin
				r.read_byte = ring_bytes[rd_ptr[idx][RING_AW-1:0]];
				rd_ptr[idx] = (rd_ptr[idx] + 1) % RING_DEPTH;
				r.accepted  = 1'b1;
			end
			// An inactive reader is reported as having nothing waiting.
			if (active) begin
				r.waiting = count_field(backlog(32'(idx)));
			end
			r.room = count_field(room_left());
			due_replies.push_back(r);
		endfunction

		task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
			mismatches++;
		endtask

		task check_reply(input logic acc, input logic [BYTE_W-1:0] rb,
			input logic [CNT_W-1:0] w, input logic [CNT_W-1:0] fs);
			reply_t want;
			if (due_replies.size() == 0) begin
				report_mismatch("response word with none due", 1, 0);
				return;
			end
			want = due_replies.pop_front();
			if (acc !== want.accepted) begin
				report_mismatch("accepted", 32'(acc), 32'(want.accepted));
			end
			if (rb !== want.read_byte) begin
				report_mismatch("read_byte", 32'(rb), 32'(want.read_byte));
			end
			if (w !== want.waiting) begin
				report_mismatch("reader_waiting", 32'(w), 32'(want.waiting));
			end
			if (fs !== want.room) begin
				report_mismatch("free_space", 32'(fs), 32'(want.room));
			end
		endtask
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	mrrb_req_if req ();
	mrrb_rsp_if rsp ();

	ring_tracker sb = new;

	// Idle controls. The sender and the receiver each insert random idle bursts
	// while their flag is set; long_hold_req asks the receiver for one long stall.
	bit tx_gaps       = 1'b1;
	bit rx_gaps       = 1'b1;
	bit long_hold_req = 1'b0;

	multi_reader_ring_buffer #(
		.DEPTH       (RING_DEPTH),
		.MAX_READERS (READERS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Offer one request word and hold it until the block takes it. The word is
	// logged with the tracker at the edge where it is accepted, so the shadow
	// state always matches what the block has seen so far.
	task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] b);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.op           <= op;
		req.reader_index <= idx;
		req.write_byte   <= b;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.log_request(op, idx, b);
	endtask

	// Stop offering and let every outstanding response drain. The extra cycles
	// cover a pointer scan that may still be running inside the block.
	task automatic settle();
		req.valid <= 1'b0;
		while (sb.due_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// The reader count is only changed while the block is idle.
	task automatic set_readers(input logic [CFG_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.reader_cfg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic. Most reads go to active readers so that bytes actually
	// move; the rest pick any reader and so also hit inactive ones.
	task automatic mixed_phase(input int n_items, input int write_pct);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < write_pct) begin
				send_word(OP_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 4) == 0) begin
				send_word(OP_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else begin
				send_word(OP_READ, 3'($urandom_range(0, sb.live_readers() - 1)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// With a single active reader, write until the ring is full and then keep
	// writing a few more words, which must all be refused. Some reads of
	// inactive readers are mixed in as noise.
	task automatic fill_to_full();
		int extra;
		extra = 0;
		while (extra < 4) begin
			if (sb.room_left() == 0) begin
				extra++;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_word(OP_READ, 3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
			end else begin
				send_word(OP_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Read reader 0 back to empty, then once more on the empty ring. Together with
	// the fill this carries both the write and the read pointer across the wrap.
	task automatic drain_reader0();
		while (sb.backlog(0) != 0) begin
			if ($urandom_range(0, 9) == 0) begin
				send_word(OP_READ, 3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)));
			end else begin
				send_word(OP_READ, 3'd0, 8'($urandom_range(0, 255)));
			end
		end
		send_word(OP_READ, 3'd0, 8'($urandom_range(0, 255)));
	endtask

	// Response side. A response word is checked at the edge where valid and ready
	// are both high. Ready drops in short random bursts, and once on request for
	// a long stretch so that the block backs up and stalls its request side.
	initial begin : reply_sink
		int stall_left;
		stall_left = 0;
		rsp.ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				sb.check_reply(rsp.accepted, rsp.read_byte, rsp.reader_waiting,
					rsp.free_space);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = 400;
			end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		req.valid        = 1'b0;
		req.op           = OP_WRITE;
		req.reader_index = '0;
		req.write_byte   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset count of one reader. A read on
		// the empty ring and a read by an inactive reader must both be refused.
		send_word(OP_READ, 3'd0, 8'h00);
		send_word(OP_READ, 3'd7, 8'hFF);
		send_word(OP_WRITE, 3'd0, 8'h00);
		// A write that reports on an inactive reader shows nothing waiting.
		send_word(OP_WRITE, 3'd7, 8'hFF);
		send_word(OP_WRITE, 3'd2, 8'hA5);
		send_word(OP_READ, 3'd0, 8'h00);
		send_word(OP_READ, 3'd1, 8'h00);

		// A count above the number of pointers acts as all readers. Reader 7
		// wakes up with its pointer still at the start and sees every byte.
		set_readers(4'd15);
		send_word(OP_READ, 3'd7, 8'h00);
		send_word(OP_READ, 3'd7, 8'h00);
		send_word(OP_READ, 3'd7, 8'h00);
		send_word(OP_READ, 3'd7, 8'h00);
		send_word(OP_WRITE, 3'd3, 8'h5A);
		send_word(OP_READ, 3'd3, 8'h00);
		send_word(OP_READ, 3'd0, 8'h00);

		// A count of zero acts as one reader; the others keep their pointers.
		set_readers(4'd0);
		send_word(OP_WRITE, 3'd5, 8'h3C);
		send_word(OP_READ, 3'd5, 8'h00);
		send_word(OP_READ, 3'd0, 8'h00);
		set_readers(4'd8);
		send_word(OP_READ, 3'd5, 8'h00);
		send_word(OP_WRITE, 3'd6, 8'hC3);

		// Deep part: fill the ring to full with the sender never pausing while
		// the receiver holds off for a long stretch, then drain it again.
		set_readers(4'd1);
		tx_gaps       = 1'b0;
		long_hold_req = 1'b1;
		fill_to_full();
		tx_gaps = 1'b1;
		drain_reader0();

		// Random phases over several reader counts, some leaning toward writes
		// and some toward reads, with idling switched on or off per phase.
		for (int p = 0; p < 6; p++) begin
			set_readers(p == 0 ? 4'd8 : 4'($urandom_range(0, 15)));
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			mixed_phase(200, (p % 2 == 0) ? 70 : 35);
		end

		// The last stretch runs at full rate on both sides.
		set_readers(4'($urandom_range(1, 8)));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		mixed_phase(150, 55);

		req.valid <= 1'b0;
		for (int t = 0; t < 2000 && sb.due_replies.size() != 0; t++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.due_replies.size() != 0) begin
			sb.report_mismatch("response words never delivered", sb.due_replies.size(), 0);
		end
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
